>>> hw/rtl/dstc_pkg.sv
// shared types, constants and small tables for the day serial to calendar time core
// no dependencies; imported by every dstc module
`default_nettype none

package dstc_pkg;

	// field widths
	localparam int FRAC_BITS  = 32;
	localparam int SERIAL_W   = 22;
	localparam int YEAR_W     = 14;

	// pipeline depth: stage 1 takes the beat, the last stage is the result register
	localparam int NUM_STAGES  = 9;
	// stage at which the time of day is final
	localparam int TIME_STAGES = 4;

	// serial constants
	localparam logic [SERIAL_W-1:0] SERIAL_MAX     = 22'd2958465;
	localparam logic [SERIAL_W-1:0] SERIAL_PHANTOM = 22'd60;
	localparam logic [SERIAL_W-1:0] CIVIL_OFFSET   = 22'd693901;
	localparam logic [SERIAL_W-1:0] DAYS_PER_ERA   = 22'd146097;
	localparam logic [YEAR_W-1:0]   EPOCH_YEAR     = 14'd1900;
	localparam logic [YEAR_W-1:0]   YEARS_PER_ERA  = 14'd400;

	// exact reciprocals: m = ceil(2^(n+l) / d), valid for every n-bit numerator
	localparam int ERA_SHIFT = 40;
	localparam logic [63:0] ERA_RECIP_W =
		((64'd1 << ERA_SHIFT) + 64'd146097 - 64'd1) / 64'd146097;
	localparam logic [22:0] ERA_RECIP = ERA_RECIP_W[22:0];

	localparam int Q1460_SHIFT = 29;
	localparam logic [63:0] Q1460_RECIP_W =
		((64'd1 << Q1460_SHIFT) + 64'd1460 - 64'd1) / 64'd1460;
	localparam logic [18:0] Q1460_RECIP = Q1460_RECIP_W[18:0];

	localparam int Y365_SHIFT = 27;
	localparam logic [63:0] Y365_RECIP_W =
		((64'd1 << Y365_SHIFT) + 64'd365 - 64'd1) / 64'd365;
	localparam logic [18:0] Y365_RECIP = Y365_RECIP_W[18:0];

	localparam int MP153_SHIFT = 19;
	localparam logic [63:0] MP153_RECIP_W =
		((64'd1 << MP153_SHIFT) + 64'd153 - 64'd1) / 64'd153;
	localparam logic [11:0] MP153_RECIP = MP153_RECIP_W[11:0];

	// time constants
	localparam logic [5:0] SEC_PER_MIN  = 6'd60;
	localparam logic [5:0] MIN_PER_HOUR = 6'd60;

	// months
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [4:0] PHANTOM_DAY = 5'd29;

	typedef struct packed {
		logic [SERIAL_W-1:0]  day_serial;
		logic [FRAC_BITS-1:0] day_fraction;
	} req_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day_of_month;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
		logic              out_of_range;
	} rsp_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day_of_month;
		logic              out_of_range;
	} date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	typedef struct packed {
		logic zero;
		logic phantom;
		logic oor;
	} serial_flags_t;

	// per-stage load enables from the flow control
	typedef struct packed {
		logic [NUM_STAGES-1:0] adv;
	} stage_ctl_t;

	// days before the start of month index mp, counted from march
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] days;
		case (mp)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'd61;
			4'd3:    days = 9'd92;
			4'd4:    days = 9'd122;
			4'd5:    days = 9'd153;
			4'd6:    days = 9'd184;
			4'd7:    days = 9'd214;
			4'd8:    days = 9'd245;
			4'd9:    days = 9'd275;
			4'd10:   days = 9'd306;
			4'd11:   days = 9'd337;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

	// calendar month of march-based month index
	function automatic logic [3:0] month_of(input logic [3:0] mp);
		logic [3:0] m;
		if (mp < 4'd10) begin
			m = mp + 4'd3;
		end else begin
			m = mp - 4'd9;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dstc_flow.sv
// valid bits and per-stage load enables of the conversion pipeline
// depends on dstc_pkg
`default_nettype none

module dstc_flow import dstc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	output logic        req_ready,
	output logic        rsp_valid,
	input  wire logic   rsp_ready,
	output stage_ctl_t  ctl
);

	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [NUM_STAGES-1:0] adv;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		adv[NUM_STAGES-1] = ~stage_vld_q[NUM_STAGES-1] | rsp_ready;
		for (int i = NUM_STAGES-2; i >= 0; i--) begin
			adv[i] = ~stage_vld_q[i] | adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[0]) begin
				stage_vld_q[0] <= req_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (adv[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	assign req_ready = adv[0];
	assign rsp_valid = stage_vld_q[NUM_STAGES-1];
	assign ctl.adv   = adv;

	// an accepted beat occupies the first stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> stage_vld_q[0])
		else $error("accepted beat not in first stage");

	// a full stage behind a held stage is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((stage_vld_q[NUM_STAGES-2:0] & ~adv[NUM_STAGES-1:1])
			& adv[NUM_STAGES-2:0]) == '0)
		else $error("stalled stage overwritten");

endmodule

`default_nettype wire

>>> hw/rtl/dstc_time.sv
// time of day split: fraction of a day to hour, minute and rounded second
// depends on dstc_pkg; stage enables come from dstc_flow
`default_nettype none

module dstc_time import dstc_pkg::*; (
	input  wire logic                 clk,
	input  wire stage_ctl_t           ctl,
	input  wire logic [FRAC_BITS-1:0] day_fraction,
	output hms_t                      hms
);

	localparam logic [FRAC_BITS+5:0] ROUND_HALF =
		{6'd0, 1'b1, {(FRAC_BITS-1){1'b0}}};

	logic [FRAC_BITS+4:0] hour_prod;
	logic [FRAC_BITS+5:0] min_prod;
	logic [FRAC_BITS+5:0] sec_prod;

	logic [4:0]           hh_s1, hh_s2, hh_s3;
	logic [FRAC_BITS-1:0] r1_s1, r2_s2;
	logic [5:0]           mi_s2, mi_s3;
	logic [5:0]           ss_s3;

	logic       sec_wrap, min_wrap;
	logic [5:0] min_next;
	hms_t       hms_next;
	hms_t       hms_s [TIME_STAGES:NUM_STAGES];

	// f * 24
	assign hour_prod = {1'b0, day_fraction, 4'b0} + {2'b0, day_fraction, 3'b0};
	// remainder * 60
	assign min_prod  = {r1_s1, 6'b0} - {4'b0, r1_s1, 2'b0};
	// remainder * 60 + one half
	assign sec_prod  = {r2_s2, 6'b0} - {4'b0, r2_s2, 2'b0} + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			hh_s1 <= hour_prod[FRAC_BITS+4:FRAC_BITS];
			r1_s1 <= hour_prod[FRAC_BITS-1:0];
		end
		if (ctl.adv[1]) begin
			hh_s2 <= hh_s1;
			mi_s2 <= min_prod[FRAC_BITS+5:FRAC_BITS];
			r2_s2 <= min_prod[FRAC_BITS-1:0];
		end
		if (ctl.adv[2]) begin
			hh_s3 <= hh_s2;
			mi_s3 <= mi_s2;
			ss_s3 <= sec_prod[FRAC_BITS+5:FRAC_BITS];
		end
	end

	// rounding carry into minute, then hour; no day carry
	assign sec_wrap = (ss_s3 == SEC_PER_MIN);
	assign min_next = sec_wrap ? mi_s3 + 6'd1 : mi_s3;
	assign min_wrap = (min_next == MIN_PER_HOUR);

	always_comb begin
		hms_next.second = sec_wrap ? 6'd0 : ss_s3;
		hms_next.minute = min_wrap ? 6'd0 : min_next;
		hms_next.hour   = min_wrap ? hh_s3 + 5'd1 : hh_s3;
	end

	// carry result, then delay to line up with the date path
	always_ff @(posedge clk) begin
		if (ctl.adv[TIME_STAGES-1]) begin
			hms_s[TIME_STAGES] <= hms_next;
		end
		for (int k = TIME_STAGES+1; k <= NUM_STAGES; k++) begin
			if (ctl.adv[k-1]) begin
				hms_s[k] <= hms_s[k-1];
			end
		end
	end

	assign hms = hms_s[NUM_STAGES];

endmodule

`default_nettype wire

>>> hw/rtl/dstc_date.sv
// day serial to gregorian year, month and day over the pipeline stages
// depends on dstc_pkg; stage enables come from dstc_flow
`default_nettype none

module dstc_date import dstc_pkg::*; (
	input  wire logic                clk,
	input  wire stage_ctl_t          ctl,
	input  wire logic [SERIAL_W-1:0] day_serial,
	output date_t                    ymd
);

	serial_flags_t        flg_in;
	logic [SERIAL_W-1:0]  days, z_next;
	serial_flags_t        flg_s [1:NUM_STAGES-1];

	logic [SERIAL_W-1:0]  z_s1, z_s2;
	logic [44:0]          era_prod;
	logic [4:0]           era_s2, era_s3, era_s4, era_s5, era_s6, era_s7;
	logic [SERIAL_W-1:0]  era_days, doe_full;
	logic [17:0]          doe_s3, doe_s4, doe_s5, doe_s6;
	logic [36:0]          q1_prod;
	logic [6:0]           q1_s4;
	logic [2:0]           cent_next, cent_s4;
	logic                 era_end_s4;
	logic [17:0]          n_s5;
	logic [36:0]          yoe_prod;
	logic [8:0]           yoe_s6, yoe_s7;
	logic [1:0]           yoe_cent;
	logic [17:0]          doy_full;
	logic [8:0]           doy_s7, doy_s8;
	logic [10:0]          mp_num;
	logic [22:0]          mp_prod;
	logic [3:0]           mp_s8;
	logic [YEAR_W-1:0]    yr_s8;
	logic [3:0]           month_c;
	logic [8:0]           dom_c;
	date_t                ymd_next, ymd_s9;

	// stage 1: range and special serials, shift to a march-based day count
	always_comb begin
		flg_in.oor     = (day_serial > SERIAL_MAX);
		flg_in.zero    = (day_serial == '0);
		flg_in.phantom = (day_serial == SERIAL_PHANTOM);
		days   = (day_serial < SERIAL_PHANTOM) ? day_serial - 22'd1 : day_serial - 22'd2;
		z_next = days + CIVIL_OFFSET;
	end

	// stage 2: era by reciprocal multiply
	assign era_prod = 45'(z_s1) * 45'(ERA_RECIP);
	// stage 3: day of era
	assign era_days = 22'(era_s2) * DAYS_PER_ERA;
	assign doe_full = z_s2 - era_days;
	// stage 4: leap corrections
	assign q1_prod   = 37'(doe_s3) * 37'(Q1460_RECIP);
	assign cent_next = 3'(doe_s3 >= 18'd36524) + 3'(doe_s3 >= 18'd73048)
		+ 3'(doe_s3 >= 18'd109572) + 3'(doe_s3 >= 18'd146096);
	// stage 6: year of era
	assign yoe_prod  = 37'(n_s5) * 37'(Y365_RECIP);
	// stage 7: day of year
	assign yoe_cent  = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
	assign doy_full  = doe_s6 - (18'(yoe_s6) * 18'd365 + 18'(yoe_s6 >> 2) - 18'(yoe_cent));
	// stage 8: month index from march
	assign mp_num    = {doy_s7, 2'b0} + 11'(doy_s7) + 11'd2;
	assign mp_prod   = 23'(mp_num) * 23'(MP153_RECIP);

	// stage 9: calendar fields and special serials
	assign month_c = month_of(mp_s8);
	assign dom_c   = doy_s8 - month_start(mp_s8) + 9'd1;

	always_comb begin
		ymd_next.year         = yr_s8 + 14'(month_c <= MONTH_FEB);
		ymd_next.month        = month_c;
		ymd_next.day_of_month = dom_c[4:0];
		ymd_next.out_of_range = 1'b0;
		if (flg_s[NUM_STAGES-1].zero) begin
			ymd_next.year         = EPOCH_YEAR;
			ymd_next.month        = MONTH_JAN;
			ymd_next.day_of_month = 5'd0;
		end else if (flg_s[NUM_STAGES-1].phantom) begin
			ymd_next.year         = EPOCH_YEAR;
			ymd_next.month        = MONTH_FEB;
			ymd_next.day_of_month = PHANTOM_DAY;
		end
		if (flg_s[NUM_STAGES-1].oor) begin
			ymd_next = '0;
			ymd_next.out_of_range = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			flg_s[1] <= flg_in;
			z_s1     <= z_next;
		end
		for (int k = 2; k <= NUM_STAGES-1; k++) begin
			if (ctl.adv[k-1]) begin
				flg_s[k] <= flg_s[k-1];
			end
		end
		if (ctl.adv[1]) begin
			z_s2   <= z_s1;
			era_s2 <= era_prod[ERA_SHIFT+4:ERA_SHIFT];
		end
		if (ctl.adv[2]) begin
			era_s3 <= era_s2;
			doe_s3 <= doe_full[17:0];
		end
		if (ctl.adv[3]) begin
			era_s4     <= era_s3;
			doe_s4     <= doe_s3;
			q1_s4      <= q1_prod[Q1460_SHIFT+6:Q1460_SHIFT];
			cent_s4    <= cent_next;
			era_end_s4 <= (doe_s3 == 18'd146096);
		end
		if (ctl.adv[4]) begin
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			n_s5   <= doe_s4 - 18'(q1_s4) + 18'(cent_s4) - 18'(era_end_s4);
		end
		if (ctl.adv[5]) begin
			era_s6 <= era_s5;
			doe_s6 <= doe_s5;
			yoe_s6 <= yoe_prod[Y365_SHIFT+8:Y365_SHIFT];
		end
		if (ctl.adv[6]) begin
			era_s7 <= era_s6;
			yoe_s7 <= yoe_s6;
			doy_s7 <= doy_full[8:0];
		end
		if (ctl.adv[7]) begin
			doy_s8 <= doy_s7;
			mp_s8  <= mp_prod[MP153_SHIFT+3:MP153_SHIFT];
			yr_s8  <= 14'(yoe_s7) + 14'(era_s7) * YEARS_PER_ERA;
		end
		if (ctl.adv[8]) begin
			ymd_s9 <= ymd_next;
		end
	end

	assign ymd = ymd_s9;

endmodule

`default_nettype wire

>>> hw/rtl/day_serial_to_calendar_time_core.sv
// top level of the day serial to calendar time core
// depends on dstc_pkg, dstc_flow, dstc_date, dstc_time
//
// usage
//   req channel: one beat carries a whole day serial of the 1900 spreadsheet
//   date system (serial 1 is 1 jan 1900, the phantom 29 feb 1900 is serial 60)
//   and a q0.32 fraction of a day
//   rsp channel: one beat per request with year, month, day of month, hour,
//   minute, rounded second and the out-of-range flag; serials past
//   31 dec 9999 set the flag and zero every other field
//   pipeline: a result passes the nine register stages of the date path
//   (range and day count, era, day of era, leap corrections, corrected day
//   count, year of era, day of year, month, final fields)
//   throughput: one beat per cycle while rsp_ready stays high; every stage holds one item
//   reset: arst_n clears all stage valid bits; the pipeline comes up empty
//   and req_ready is high at once
//   stall: when rsp_ready is low the last stage holds its beat; stages behind
//   it keep filling until they meet a full one, then req_ready drops
//   the hour reads 24 when rounding carries through minute and hour
`default_nettype none

module day_serial_to_calendar_time_core import dstc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req_data,

	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp_data
);

	stage_ctl_t ctl;
	date_t      ymd;
	hms_t       hms;

	// valid bits and stage load enables
	dstc_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	// calendar date path
	dstc_date u_date (
		.clk        (clk),
		.ctl        (ctl),
		.day_serial (req_data.day_serial),
		.ymd        (ymd)
	);

	// time of day path, delayed to line up with the date
	dstc_time u_time (
		.clk          (clk),
		.ctl          (ctl),
		.day_fraction (req_data.day_fraction),
		.hms          (hms)
	);

	// result beat; time fields forced to zero for an out-of-range serial
	always_comb begin
		rsp_data.year         = ymd.year;
		rsp_data.month        = ymd.month;
		rsp_data.day_of_month = ymd.day_of_month;
		rsp_data.out_of_range = ymd.out_of_range;
		rsp_data.hour         = ymd.out_of_range ? 5'd0 : hms.hour;
		rsp_data.minute       = ymd.out_of_range ? 6'd0 : hms.minute;
		rsp_data.second       = ymd.out_of_range ? 6'd0 : hms.second;
	end

	// an in-range result always carries a real month and a year in range
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.out_of_range |->
			rsp_data.month >= MONTH_JAN && rsp_data.month <= 4'd12
			&& rsp_data.year >= EPOCH_YEAR && rsp_data.year <= 14'd9999)
		else $error("calendar field out of range");

	// time fields stay within their carries
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.hour <= 5'd24 && rsp_data.minute < MIN_PER_HOUR
			&& rsp_data.second < SEC_PER_MIN)
		else $error("time field out of range");

endmodule

`default_nettype wire

>>> tb/sv/tb_day_serial_to_calendar_time_core.sv
// self-checking testbench for day_serial_to_calendar_time_core
// holds its own calendar and clock-split predictor in a small scoreboard class
// depends on dstc_pkg and the core rtl only
`timescale 1ns / 100ps
`default_nettype none

module tb_day_serial_to_calendar_time_core import dstc_pkg::*;;

	// clock, reset and the two channels
	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	// while set, neither side idles
	bit steady;

	// expected results in order, plus the calendar / time-of-day prediction
	class calendar_scoreboard;
		rsp_t        expected_q[$];
		int unsigned mismatch_count;

		// days since 1 jan 1900 in the true gregorian calendar to y/m/d,
		// then the fraction split into hour, minute and rounded second
		function rsp_t predict_calendar(req_t item);
			rsp_t        want;
			int unsigned serial;
			int unsigned days;
			int unsigned z;
			int unsigned era;
			int unsigned doe;
			int unsigned yoe;
			int unsigned doy;
			int unsigned mp;
			int unsigned yr;
			logic [63:0] t;
			logic [63:0] hh;
			logic [63:0] mi;
			logic [63:0] ss;
			want = '0;
			serial = item.day_serial;
			// past 31 dec 9999 only the flag is set
			if (item.day_serial > SERIAL_MAX) begin
				want.out_of_range = 1'b1;
				return want;
			end
			if (serial == 0) begin
				// serial zero reads as day 0 of january 1900
				want.year = EPOCH_YEAR;
				want.month = MONTH_JAN;
				want.day_of_month = 5'd0;
			end else if (item.day_serial == SERIAL_PHANTOM) begin
				// the fictitious leap day of 1900
				want.year = EPOCH_YEAR;
				want.month = MONTH_FEB;
				want.day_of_month = PHANTOM_DAY;
			end else begin
				// serials past the phantom day are one day ahead of the real calendar
				days = (item.day_serial < SERIAL_PHANTOM) ? serial - 1 : serial - 2;
				z = days + CIVIL_OFFSET;
				era = z / DAYS_PER_ERA;
				doe = z - era * DAYS_PER_ERA;
				yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
				doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
				mp = (5 * doy + 2) / 153;
				yr = yoe + era * YEARS_PER_ERA;
				want.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
				want.month = (mp < 10) ? 4'(mp + 3) : 4'(mp - 9);
				if (want.month <= MONTH_FEB) begin
					yr++;
				end
				want.year = YEAR_W'(yr);
			end
			// hour and minute truncate, the second rounds half up
			t = 64'(item.day_fraction) * 64'd24;
			hh = t >> FRAC_BITS;
			t = (t - (hh << FRAC_BITS)) * 64'd60;
			mi = t >> FRAC_BITS;
			t = (t - (mi << FRAC_BITS)) * 64'd60;
			ss = (t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			// carries ripple up to the hour but never into the day
			if (ss >= 64'(SEC_PER_MIN)) begin
				ss = 0;
				mi++;
			end
			if (mi >= 64'(MIN_PER_HOUR)) begin
				mi = 0;
				hh++;
			end
			want.hour = 5'(hh);
			want.minute = 6'(mi);
			want.second = 6'(ss);
			return want;
		endfunction

		function void note_request(req_t item);
			expected_q.push_back(predict_calendar(item));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			bit   bad;
			if (expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: result beat with nothing expected: %p", $realtime, got);
				end
				return;
			end
			want = expected_q.pop_front();
			bad = (got.year !== want.year) || (got.month !== want.month)
				|| (got.day_of_month !== want.day_of_month) || (got.hour !== want.hour)
				|| (got.minute !== want.minute) || (got.second !== want.second)
				|| (got.out_of_range !== want.out_of_range);
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: result mismatch\n  expected %p\n  actual   %p",
						$realtime, want, got);
				end
			end
		endfunction
	endclass

	calendar_scoreboard sb = new();

	day_serial_to_calendar_time_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one request beat, idling first now and then; returns once accepted
	task automatic send_beat(input req_t item);
		int unsigned gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 5) begin
			gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (req_ready !== 1'b1);
		sb.note_request(item);
	endtask

	// drop valid and let every outstanding result come back
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic req_t make_request(logic [SERIAL_W-1:0] serial,
		logic [FRAC_BITS-1:0] fraction);
		req_t item;
		item.day_serial = serial;
		item.day_fraction = fraction;
		return item;
	endfunction

	// random request, weighted toward the interesting corners
	function automatic req_t random_request();
		req_t        item;
		logic [63:0] mark;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				item.day_serial = SERIAL_W'($urandom_range(1, SERIAL_MAX));
			end
			// around serial zero, the phantom day and the first years
			6: begin
				item.day_serial = SERIAL_W'($urandom_range(0, 800));
			end
			// both sides of the last valid day
			7: begin
				item.day_serial = SERIAL_W'($urandom_range(SERIAL_MAX - 300, SERIAL_MAX + 300));
			end
			default: begin
				item.day_serial = SERIAL_W'($urandom());
			end
		endcase
		case ($urandom_range(0, 9))
			// odd multiples of 2^24 land exactly on a half second
			6: begin
				item.day_fraction = FRAC_BITS'(($urandom_range(0, 127) * 2 + 1)) << 24;
			end
			// up to 40000 steps below a minute edge; within half a second of it the second carries
			7, 8: begin
				mark = (64'($urandom_range(1, 1440)) << FRAC_BITS) / 64'd1440;
				item.day_fraction = FRAC_BITS'(mark - 64'($urandom_range(0, 40000)));
			end
			default: begin
				item.day_fraction = FRAC_BITS'($urandom());
			end
		endcase
		return item;
	endfunction

	// result side: stall now and then, check every accepted beat
	initial begin
		forever begin
			rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready) begin
				sb.check_response(rsp_data);
			end
		end
	end

	// request side: reset, directed corners, random beats, drain, verdict
	initial begin
		req_t directed_q[$];
		steady = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// serial zero, start of 1900 and the phantom leap day around it
		directed_q.push_back(make_request(22'd0, 32'h0000_0000));
		directed_q.push_back(make_request(22'd1, 32'hFFFF_FFFF));
		directed_q.push_back(make_request(22'd59, 32'h4000_0000));
		directed_q.push_back(make_request(SERIAL_PHANTOM, 32'h8000_0000));
		directed_q.push_back(make_request(22'd61, 32'hC000_0000));
		// year ends of 1900 and the real leap day of 2000
		directed_q.push_back(make_request(22'd366, 32'h0000_0001));
		directed_q.push_back(make_request(22'd367, 32'h7FFF_FFFF));
		directed_q.push_back(make_request(22'd36585, 32'h1234_5678));
		directed_q.push_back(make_request(22'd36586, 32'h0100_0000));
		// last valid day, the first one past it and the largest serial
		directed_q.push_back(make_request(SERIAL_MAX, 32'hFFFF_FFFF));
		directed_q.push_back(make_request(SERIAL_MAX + 22'd1, 32'hFFFF_FFFF));
		directed_q.push_back(make_request(22'h3F_FFFF, 32'hFFFF_FFFF));
		// alternating bit patterns on both fields
		directed_q.push_back(make_request(22'h2A_AAAA, 32'hAAAA_AAAA));
		directed_q.push_back(make_request(22'h15_5555, 32'h5555_5555));
		// exact half-second tie rounds up
		directed_q.push_back(make_request(22'd45000, 32'h0300_0000));
		// second carries into the minute only, then through to hour 24
		directed_q.push_back(make_request(22'd45001, 32'h002D_82D8));
		directed_q.push_back(make_request(22'd45002, 32'hFFFF_A000));
		directed_q.push_back(make_request(22'd45003, 32'h0AAA_AAAA));
		foreach (directed_q[i]) begin
			send_beat(directed_q[i]);
		end

		// pause until the pipeline is empty before the random part
		hold_until_drained();

		for (int i = 0; i < 900; i++) begin
			// a long stretch where neither side idles
			steady = (i >= 300 && i < 450);
			if (i == 600) begin
				hold_until_drained();
			end
			send_beat(random_request());
		end
		steady = 1'b0;

		hold_until_drained();
		repeat (NUM_STAGES + 4) @(posedge clk);
		if (sb.mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

>>> day_serial_to_calendar_time_core.f
hw/rtl/dstc_pkg.sv
hw/rtl/dstc_flow.sv
hw/rtl/dstc_time.sv
hw/rtl/dstc_date.sv
hw/rtl/day_serial_to_calendar_time_core.sv
tb/sv/tb_day_serial_to_calendar_time_core.sv
